>>> rtl/usr_pkg.sv
// Shared constants, codes and types for the ultrasonic scan ranger.
`timescale 1ns / 1ps

package usr_pkg;

   localparam int unsigned SENSOR_COUNT_DEFAULT = 6;

   localparam int unsigned TIME_WIDTH    = 32;
   localparam int unsigned CMD_WIDTH     = 2;
   localparam int unsigned SLOT_WIDTH    = 3;
   localparam int unsigned CM_WIDTH      = 10;
   localparam int unsigned SWEEP_WIDTH   = 8;
   localparam int unsigned PHASE_WIDTH   = 4;
   localparam int unsigned REQ_DATA_WIDTH = 40;
   localparam int unsigned RSP_DATA_WIDTH = 40;

   localparam logic [CMD_WIDTH-1:0] CMD_POLL = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_RISE = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_FALL = 2'd2;

   localparam logic [PHASE_WIDTH-1:0] PHASE_MAX    = 4'd15;
   localparam logic [SWEEP_WIDTH-1:0] SWEEP_MAX    = 8'd255;
   localparam logic [CM_WIDTH-1:0]    MAX_DIST_RST = 10'd244;

   // width / 58 == (width >> 1) / 29; 29 * 36158 = 2^20 + 6, exact below 2^15
   localparam int unsigned    QUOT_WIDTH = CM_WIDTH + 1;
   localparam int unsigned    CM_SHIFT   = 20;
   localparam logic [15:0]    CM_RECIP   = 16'd36158;

   typedef struct packed {
      logic                  fits;
      logic [QUOT_WIDTH-1:0] cm;
   } cm_result_type;

endpackage

>>> rtl/usr_cm_divider.sv
// Echo width to centimetres: reciprocal multiply by 1/58 with range flag.
`timescale 1ns / 1ps

module usr_cm_divider (
   input  logic [usr_pkg::TIME_WIDTH-1:0] echo_width,
   output usr_pkg::cm_result_type         result
);

   localparam int unsigned PROD_WIDTH = usr_pkg::CM_SHIFT + usr_pkg::QUOT_WIDTH;

   logic [14:0]           half_width;
   logic [PROD_WIDTH-1:0] product;

   assign half_width = echo_width[15:1];
   assign product    = PROD_WIDTH'(half_width) * PROD_WIDTH'(usr_pkg::CM_RECIP);

   // widths of 2^16 and above exceed any storable distance
   assign result.fits = (echo_width[usr_pkg::TIME_WIDTH-1:16] == '0);
   assign result.cm   = product[usr_pkg::CM_SHIFT +: usr_pkg::QUOT_WIDTH];

endmodule

>>> rtl/ultrasonic_scan_ranger.sv
// Top level of the six-way multiplexed ultrasonic echo ranger.
`timescale 1ns / 1ps
//
//  Channel | Ports        | Carries
//  --------+--------------+---------------------------------------------------
//  request | req_t*       | poll / echo-rise / echo-fall event with timestamp
//  result  | rsp_t*       | trigger, address, store report, sweeps, read-back
//  config  | csr_wr_*     | range limit in cm, written while idle
//
//  One transaction per cycle while results are taken: input register,
//  combinational logic (one 15x16 multiply for the cm conversion), result register.
//  Synchronous reset clears phase, timestamps, distances, sweep count and
//  address, and sets the range limit to 244.
//  A stalled result holds; the input register takes a transaction while empty,
//  or while the result register is free or being taken in the same cycle.

module ultrasonic_scan_ranger #(
   parameter int unsigned SENSOR_COUNT = usr_pkg::SENSOR_COUNT_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // time_us[31:0], read_slot[34:32], zero[39:35]
   input  logic [usr_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,
   // command[1:0]
   input  logic [usr_pkg::CMD_WIDTH-1:0]       req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // trigger_fired[0], sensor_address[3:1], stored[4], stored_slot[7:5],
   // stored_cm[17:8], full_sweeps[25:18], read_cm[35:26], zero[39:36]
   output logic [usr_pkg::RSP_DATA_WIDTH-1:0]  rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [usr_pkg::CM_WIDTH-1:0]        csr_wr_data
);

   localparam int unsigned TW = usr_pkg::TIME_WIDTH;
   localparam int unsigned SW = usr_pkg::SLOT_WIDTH;
   localparam int unsigned CW = usr_pkg::CM_WIDTH;
   localparam int unsigned PW = usr_pkg::PHASE_WIDTH;
   localparam int unsigned GW = usr_pkg::SWEEP_WIDTH;

   localparam logic [PW:0]   PHASE_LAST = (PW + 1)'(2 * SENSOR_COUNT);
   localparam logic [SW:0]   SLOT_LIMIT = (SW + 1)'(SENSOR_COUNT);
   localparam int unsigned   RSP_USED   = 1 + SW + 1 + SW + CW + GW + CW;

   logic                           in_valid_ff, in_valid_in;
   logic [usr_pkg::CMD_WIDTH-1:0]  in_cmd_ff;
   logic [TW-1:0]                  in_time_ff;
   logic [SW-1:0]                  in_slot_ff;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [RSP_USED-1:0]            rsp_data_ff, rsp_data_in;

   logic [CW-1:0]                  max_dist_ff, max_dist_in;
   logic [PW-1:0]                  phase_ff, phase_in;
   logic [TW-1:0]                  rise_ff, rise_in;
   logic [TW-1:0]                  echo_ff, echo_in;
   logic [GW-1:0]                  sweep_ff, sweep_in;
   logic [SW-1:0]                  addr_ff, addr_in;
   logic [CW-1:0]                  dist_ff [SENSOR_COUNT];

   logic                           advance;
   logic                           req_take;
   usr_pkg::cm_result_type         div_result;
   logic                           poll_act;
   logic                           wrap;
   logic [PW-1:0]                  phase_base;
   logic [SW-1:0]                  slot_idx;
   logic                           store_en;
   logic [CW-1:0]                  store_cm;
   logic [CW-1:0]                  read_cm;

   usr_cm_divider u_cm_divider (
      .echo_width (echo_ff),
      .result     (div_result)
   );

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
      max_dist_in  = csr_wr_en ? csr_wr_data : max_dist_ff;
   end

   always_comb begin
      poll_act   = (in_cmd_ff == usr_pkg::CMD_POLL) && !phase_ff[0]
                   && ({1'b0, phase_ff} <= PHASE_LAST);
      wrap       = ({1'b0, phase_ff} >= PHASE_LAST);
      phase_base = wrap ? '0 : phase_ff;
      slot_idx   = SW'(phase_ff[PW-1:1] - 3'd1);
      store_en   = poll_act && (phase_ff != '0) && div_result.fits
                   && (div_result.cm <= {1'b0, max_dist_ff})
                   && ({1'b0, slot_idx} < SLOT_LIMIT);
      store_cm   = div_result.cm[CW-1:0];

      phase_in = phase_ff;
      rise_in  = rise_ff;
      echo_in  = echo_ff;
      sweep_in = sweep_ff;
      addr_in  = addr_ff;
      if (advance) begin
         case (in_cmd_ff)
            usr_pkg::CMD_POLL: begin
               if (poll_act) begin
                  phase_in = phase_base + 4'd1;
                  addr_in  = phase_base[PW-1:1];
                  if (wrap && (sweep_ff != usr_pkg::SWEEP_MAX)) begin
                     sweep_in = sweep_ff + 8'd1;
                  end
               end
            end
            usr_pkg::CMD_RISE: begin
               rise_in = in_time_ff;
            end
            usr_pkg::CMD_FALL: begin
               echo_in = in_time_ff - rise_ff;
               if (phase_ff != usr_pkg::PHASE_MAX) begin
                  phase_in = phase_ff + 4'd1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      read_cm = '0;
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (in_slot_ff == SW'(i)) begin
            read_cm = (store_en && (slot_idx == SW'(i))) ? store_cm : dist_ff[i];
         end
      end
      rsp_data_in = {read_cm,
                     sweep_in,
                     store_en ? store_cm : {CW{1'b0}},
                     store_en ? slot_idx : {SW{1'b0}},
                     store_en,
                     addr_in,
                     poll_act};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_dist_ff  <= usr_pkg::MAX_DIST_RST;
         phase_ff     <= '0;
         rise_ff      <= '0;
         echo_ff      <= '0;
         sweep_ff     <= '0;
         addr_ff      <= '0;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            dist_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         max_dist_ff  <= max_dist_in;
         phase_ff     <= phase_in;
         rise_ff      <= rise_in;
         echo_ff      <= echo_in;
         sweep_ff     <= sweep_in;
         addr_ff      <= addr_in;
         for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (advance && store_en && (slot_idx == SW'(i))) begin
               dist_ff[i] <= store_cm;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= req_tuser;
         in_time_ff <= req_tdata[TW-1:0];
         in_slot_ff <= req_tdata[TW +: SW];
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = usr_pkg::RSP_DATA_WIDTH'(rsp_data_ff);

   a_store_needs_trigger : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[0])
      else $error("distance stored without a trigger");

   a_address_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> ({1'b0, rsp_tdata[3:1]} < SLOT_LIMIT))
      else $error("trigger fired on an address beyond the last sensor");

   a_sweeps_monotonic : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> sweep_ff >= $past(sweep_ff))
      else $error("sweep count went backwards");

endmodule

>>> test/tb.sv
// Self-checking testbench for the ultrasonic scan ranger: streamed events against a predictor.
`timescale 1ns / 1ps

module tb;

   localparam int unsigned CMD_WIDTH      = usr_pkg::CMD_WIDTH;
   localparam int unsigned TIME_WIDTH     = usr_pkg::TIME_WIDTH;
   localparam int unsigned SLOT_WIDTH     = usr_pkg::SLOT_WIDTH;
   localparam int unsigned CM_WIDTH       = usr_pkg::CM_WIDTH;
   localparam int unsigned SWEEP_WIDTH    = usr_pkg::SWEEP_WIDTH;
   localparam int unsigned PHASE_WIDTH    = usr_pkg::PHASE_WIDTH;
   localparam int unsigned REQ_DATA_WIDTH = usr_pkg::REQ_DATA_WIDTH;
   localparam int unsigned RSP_DATA_WIDTH = usr_pkg::RSP_DATA_WIDTH;

   localparam logic [CMD_WIDTH-1:0]   CMD_POLL  = usr_pkg::CMD_POLL;
   localparam logic [CMD_WIDTH-1:0]   CMD_RISE  = usr_pkg::CMD_RISE;
   localparam logic [CMD_WIDTH-1:0]   CMD_FALL  = usr_pkg::CMD_FALL;
   localparam logic [PHASE_WIDTH-1:0] PHASE_MAX = usr_pkg::PHASE_MAX;
   localparam logic [SWEEP_WIDTH-1:0] SWEEP_MAX = usr_pkg::SWEEP_MAX;

   localparam int unsigned SENSORS    = usr_pkg::SENSOR_COUNT_DEFAULT;
   localparam int unsigned CM_DIVISOR = 58;
   localparam logic [CMD_WIDTH-1:0] CMD_IDLE = 2'd3;
   localparam int unsigned SLOT_LSB   = TIME_WIDTH;
   localparam int unsigned PAD_WIDTH  = REQ_DATA_WIDTH - TIME_WIDTH - SLOT_WIDTH;
   localparam int unsigned SEGMENT_LEN = 200;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]  cmd;
      logic [TIME_WIDTH-1:0] stamp;
      logic [SLOT_WIDTH-1:0] slot;
   } echo_event_type;

   typedef struct packed {
      logic [RSP_DATA_WIDTH-37:0] pad;
      logic [CM_WIDTH-1:0]        read_cm;
      logic [SWEEP_WIDTH-1:0]     sweeps;
      logic [CM_WIDTH-1:0]        stored_cm;
      logic [SLOT_WIDTH-1:0]      stored_slot;
      logic                       stored;
      logic [SLOT_WIDTH-1:0]      address;
      logic                       fired;
   } ranger_rsp_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic [CMD_WIDTH-1:0]      req_tuser = CMD_IDLE;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_wr_en = 1'b0;
   logic [CM_WIDTH-1:0]       csr_wr_data = '0;

   ultrasonic_scan_ranger #(.SENSOR_COUNT(SENSORS)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [PHASE_WIDTH-1:0] ph = '0;
   logic [TIME_WIDTH-1:0]  rise_stamp = '0;
   logic [TIME_WIDTH-1:0]  echo_len = '0;
   logic [CM_WIDTH-1:0]    slot_cm [SENSORS];
   logic [SWEEP_WIDTH-1:0] sweeps = '0;
   logic [SLOT_WIDTH-1:0]  mux_addr = '0;
   logic [CM_WIDTH-1:0]    max_dist = usr_pkg::MAX_DIST_RST;

   // stimulus-side phase tracking
   logic [PHASE_WIDTH-1:0] gen_phase = '0;

   echo_event_type pending_events [$];
   ranger_rsp_type expected_rsp [$];

   int unsigned errors = 0;
   int unsigned events_sent = 0;
   int unsigned results_checked = 0;
   int unsigned settings_used = 1;
   int unsigned send_gap = 0;
   int unsigned recv_hold = 0;
   bit          send_idle_on = 1'b1;
   bit          recv_idle_on = 1'b1;

   initial begin
      for (int i = 0; i < SENSORS; i++) slot_cm[i] = '0;
   end

   task automatic predict_ranger(input logic [CMD_WIDTH-1:0] cmd,
                                 input logic [TIME_WIDTH-1:0] stamp,
                                 input logic [SLOT_WIDTH-1:0] slot,
                                 output ranger_rsp_type r);
      logic [TIME_WIDTH-1:0]  quot;
      logic [PHASE_WIDTH-1:0] idx;
      r = '0;
      case (cmd)
         CMD_POLL: begin
            if (!ph[0] && ph <= 2 * SENSORS) begin
               if (ph > 0) begin
                  quot = echo_len / CM_DIVISOR;
                  idx = ph / 2 - 1;
                  if (quot <= max_dist && idx < SENSORS) begin
                     slot_cm[idx] = quot[CM_WIDTH-1:0];
                     r.stored = 1'b1;
                     r.stored_slot = idx[SLOT_WIDTH-1:0];
                     r.stored_cm = quot[CM_WIDTH-1:0];
                  end
               end
               if (ph >= 2 * SENSORS) begin
                  ph = '0;
                  if (sweeps != SWEEP_MAX) sweeps++;
               end
               mux_addr = ph[SLOT_WIDTH:1];
               r.fired = 1'b1;
               ph++;
            end
         end
         CMD_RISE: rise_stamp = stamp;
         CMD_FALL: begin
            echo_len = stamp - rise_stamp;
            if (ph != PHASE_MAX) ph++;
         end
         default: ;
      endcase
      r.address = mux_addr;
      r.sweeps = sweeps;
      r.read_cm = (slot < SENSORS) ? slot_cm[slot] : '0;
   endtask

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      errors++;
      $display("tb: mismatch at result %0d: %s expected %0d got %0d",
               results_checked, what, want, got);
   endtask

   // drive request transactions
   always @(posedge clock) begin : drive
      echo_event_type next;
      ranger_rsp_type want;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_ranger(req_tuser, req_tdata[TIME_WIDTH-1:0],
                           req_tdata[SLOT_LSB +: SLOT_WIDTH], want);
            expected_rsp.push_back(want);
            events_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (pending_events.size() > 0) begin
               next = pending_events.pop_front();
               req_tuser <= next.cmd;
               req_tdata <= {{PAD_WIDTH{1'b0}}, next.slot, next.stamp};
               req_tvalid <= 1'b1;
               send_gap = send_idle_on ? $urandom_range(0, 6) : 0;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // check result transactions
   always @(posedge clock) begin : watch
      ranger_rsp_type got;
      ranger_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_rsp.size() == 0) begin
               report_mismatch("result with none expected", 0, got[31:0]);
            end else begin
               want = expected_rsp.pop_front();
               if (got.fired != want.fired)
                  report_mismatch("trigger_fired", want.fired, got.fired);
               if (got.address != want.address)
                  report_mismatch("sensor_address", want.address, got.address);
               if (got.stored != want.stored)
                  report_mismatch("stored", want.stored, got.stored);
               if (got.stored_slot != want.stored_slot)
                  report_mismatch("stored_slot", want.stored_slot, got.stored_slot);
               if (got.stored_cm != want.stored_cm)
                  report_mismatch("stored_cm", want.stored_cm, got.stored_cm);
               if (got.sweeps != want.sweeps)
                  report_mismatch("full_sweeps", want.sweeps, got.sweeps);
               if (got.read_cm != want.read_cm)
                  report_mismatch("read_cm", want.read_cm, got.read_cm);
            end
            results_checked++;
            recv_hold = recv_idle_on ? $urandom_range(0, 6) : 0;
         end
         if (recv_hold > 0) begin
            recv_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic logic [SLOT_WIDTH-1:0] rand_slot();
      return SLOT_WIDTH'($urandom_range(0, 7));
   endfunction

   task automatic push_event(input logic [CMD_WIDTH-1:0] cmd,
                             input logic [TIME_WIDTH-1:0] stamp,
                             input logic [SLOT_WIDTH-1:0] slot);
      echo_event_type e;
      e.cmd = cmd;
      e.stamp = stamp;
      e.slot = slot;
      pending_events.push_back(e);
      case (cmd)
         CMD_POLL: begin
            if (!gen_phase[0] && gen_phase <= 2 * SENSORS) begin
               if (gen_phase >= 2 * SENSORS) begin
                  gen_phase = '0;
               end
               gen_phase++;
            end
         end
         CMD_FALL: if (gen_phase != PHASE_MAX) gen_phase++;
         default: ;
      endcase
   endtask

   function automatic logic [TIME_WIDTH-1:0] pick_width();
      case ($urandom_range(0, 9))
         0:       return $urandom_range(0, CM_DIVISOR - 1);
         1, 2:    return $urandom;
         default: return CM_DIVISOR * $urandom_range(0, 1100) + $urandom_range(0, 57);
      endcase
   endfunction

   task automatic push_echo();
      logic [TIME_WIDTH-1:0] start;
      start = $urandom;
      push_event(CMD_RISE, start, rand_slot());
      push_event(CMD_FALL, start + pick_width(), rand_slot());
   endtask

   task automatic wait_idle();
      while (pending_events.size() > 0 || req_tvalid || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_range_limit(input logic [CM_WIDTH-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      max_dist = value;
      settings_used++;
      send_idle_on = ($urandom_range(0, 3) != 0);
      recv_idle_on = ($urandom_range(0, 3) != 0);
   endtask

   task automatic random_segment(input int unsigned count);
      int unsigned done;
      logic [CMD_WIDTH-1:0] cmd;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 3) != 0) begin
            // well-formed poll / echo / poll sequence
            if (!gen_phase[0]) begin
               push_event(CMD_POLL, $urandom, rand_slot());
               done++;
            end
            push_echo();
            push_event(CMD_POLL, $urandom, rand_slot());
            done += 3;
         end else begin
            cmd = CMD_WIDTH'($urandom_range(0, 3));
            // keep the phase within reach of a poll
            if (cmd == CMD_FALL && gen_phase >= 2 * SENSORS) cmd = CMD_RISE;
            push_event(cmd, $urandom, rand_slot());
            if (cmd != CMD_IDLE) done++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: boundaries, wraparound, out-of-range slots, one full sweep
      push_event(CMD_IDLE, 32'hFFFF_FFFF, 3'd7);
      push_event(CMD_POLL, 32'h0, 3'd6);
      push_event(CMD_POLL, 32'h0, 3'd0);
      push_event(CMD_RISE, 32'd100, 3'd5);
      push_event(CMD_FALL, 32'd100 + CM_DIVISOR * 244 + 57, 3'd0);
      push_event(CMD_POLL, 32'h0, 3'd0);
      push_event(CMD_RISE, 32'hFFFF_FFF0, 3'd1);
      push_event(CMD_FALL, 32'h0000_0010, 3'd1);
      push_event(CMD_POLL, 32'h0, 3'd1);
      push_event(CMD_RISE, 32'h0, 3'd2);
      push_event(CMD_FALL, CM_DIVISOR * 245, 3'd2);
      push_event(CMD_POLL, 32'h0, 3'd2);
      push_event(CMD_RISE, 32'h0, 3'd3);
      push_event(CMD_FALL, 32'hFFFF_FFFF, 3'd3);
      push_event(CMD_POLL, 32'h0, 3'd3);
      push_event(CMD_FALL, 32'd12345, 3'd4);
      push_event(CMD_POLL, 32'h0, 3'd4);
      push_event(CMD_RISE, 32'h0, 3'd5);
      push_event(CMD_FALL, CM_DIVISOR * 100, 3'd5);
      push_event(CMD_POLL, 32'hFFFF_FFFF, 3'd5);
      push_event(CMD_IDLE, 32'h0, 3'd5);
      push_event(CMD_POLL, 32'h0, 3'd7);

      random_segment(SEGMENT_LEN);
      write_range_limit(10'd0);
      random_segment(SEGMENT_LEN);
      write_range_limit(10'd1023);
      random_segment(SEGMENT_LEN);
      write_range_limit(10'd1);
      random_segment(SEGMENT_LEN);
      write_range_limit(CM_WIDTH'($urandom_range(0, 1023)));
      random_segment(SEGMENT_LEN);

      // push the phase out of step into saturation; polls then stay inert
      for (int i = 0; i < 16; i++) push_event(CMD_FALL, $urandom, i[SLOT_WIDTH-1:0]);
      for (int i = 0; i < 8; i++) push_event(CMD_POLL, $urandom, i[SLOT_WIDTH-1:0]);
      push_event(CMD_RISE, $urandom, 3'd0);
      push_event(CMD_IDLE, $urandom, 3'd2);

      while (pending_events.size() > 0 || req_tvalid || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("tb: %0d events sent, %0d results checked, %0d range limit settings",
               events_sent, results_checked, settings_used);
      $display("tb: sweep count ended at %0d, phase ended at %0d", sweeps, ph);
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: %0d mismatches", errors);
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("tb: timeout");
      $display("tb: failure");
      $finish;
   end

endmodule
